/* src/mvm_pkg.sv */
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector MAC lanes
// Item layouts, action codes, controller states and lane control bundle.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int ITEM_LANES = 4;
    localparam int DATA_W     = 32;
    localparam int GROUP_W    = 6;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int SUM_W      = SHIFT_W + 1;

    localparam int DEF_LANES  = 4;
    localparam int DEF_GROUPS = 64;

    typedef logic signed [DATA_W-1:0] q_t;

    typedef enum logic [1:0] {
        ACT_PRELOAD = 2'd0,
        ACT_MAC     = 2'd1,
        ACT_READ    = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [GROUP_W-1:0] group;
        q_t                 weight;
        q_t                 lane_a;
        q_t                 lane_b;
        q_t                 lane_c;
        q_t                 lane_d;
    } in_item_t;

    typedef struct packed {
        logic [GROUP_W-1:0] group_out;
        q_t                 acc_a;
        q_t                 acc_b;
        q_t                 acc_c;
        q_t                 acc_d;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic is_preload;
        logic is_mac;
    } lane_ctl_t;

endpackage

/* src/mvm_stream_if.sv */
// ----------------------------------------------------------------------------
// mvm_stream_if: valid/ready channel
// Carries one item per handshake; an item moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface mvm_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

/* src/mvm_lane.sv */
// ----------------------------------------------------------------------------
// mvm_lane: one accumulator lane
// Holds the lane's accumulator memory, the Q16.16 multiplier and the
// saturating accumulate that produces the lane's new value.
// ----------------------------------------------------------------------------
module mvm_lane #(
    parameter int GROUPS = mvm_pkg::DEF_GROUPS,
    parameter int AW     = 6
) (
    input  logic              clk,
    input  mvm_pkg::lane_ctl_t ctl,
    input  logic [AW-1:0]     addr,
    input  mvm_pkg::q_t       weight,
    input  mvm_pkg::q_t       col,
    output mvm_pkg::q_t       value,
    output logic              sat
);

    mvm_pkg::q_t                          mem [GROUPS];
    mvm_pkg::q_t                          rd_data_reg;
    logic signed [mvm_pkg::PROD_W-1:0]    prod_reg;
    logic signed [mvm_pkg::SHIFT_W-1:0]   shifted;
    logic signed [mvm_pkg::SUM_W-1:0]     sum;
    logic                                 ovf;
    mvm_pkg::q_t                          new_val;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= new_val;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            prod_reg <= weight * col;
        end
    end

    // Dropping the low fraction bits of the product is a floor shift.
    assign shifted = prod_reg[mvm_pkg::PROD_W-1:mvm_pkg::FRAC_BITS];
    assign sum     = {{(mvm_pkg::SUM_W - mvm_pkg::DATA_W){rd_data_reg[mvm_pkg::DATA_W-1]}},
                      rd_data_reg}
                   + {shifted[mvm_pkg::SHIFT_W-1], shifted};
    assign ovf     = sum[mvm_pkg::SUM_W-1:mvm_pkg::DATA_W-1]
                     != {(mvm_pkg::SUM_W - mvm_pkg::DATA_W + 1){sum[mvm_pkg::SUM_W-1]}};

    always_comb
    begin
        if (ctl.is_preload)
        begin
            new_val = col;
        end
        else if (ctl.is_mac)
        begin
            if (ovf)
            begin
                new_val = sum[mvm_pkg::SUM_W-1] ? {1'b1, {(mvm_pkg::DATA_W-1){1'b0}}}
                                                : {1'b0, {(mvm_pkg::DATA_W-1){1'b1}}};
            end
            else
            begin
                new_val = sum[mvm_pkg::DATA_W-1:0];
            end
        end
        else
        begin
            new_val = rd_data_reg;
        end
    end

    assign value = new_val;
    assign sat   = ctl.is_mac & ovf;

endmodule

/* src/mvm_merge.sv */
// ----------------------------------------------------------------------------
// mvm_merge: result merge and output register
// Gathers the lane values and saturation flags into one result item and
// holds it until the receiver takes it.
// ----------------------------------------------------------------------------
module mvm_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic [mvm_pkg::GROUP_W-1:0]  group,
    input  logic                         in_range,
    input  mvm_pkg::q_t                  vals [mvm_pkg::ITEM_LANES],
    input  logic [mvm_pkg::ITEM_LANES-1:0] sats,
    output logic                         free,
    mvm_stream_if.source                 rsp
);

    logic               out_valid_reg;
    mvm_pkg::out_item_t out_data_reg;
    mvm_pkg::out_item_t out_next;

    always_comb
    begin
        out_next           = '0;
        out_next.group_out = group;
        if (in_range)
        begin
            out_next.acc_a     = vals[0];
            out_next.acc_b     = vals[1];
            out_next.acc_c     = vals[2];
            out_next.acc_d     = vals[3];
            out_next.saturated = |sats;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_next;
        end
    end

    assign free      = !out_valid_reg || rsp.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule

/* src/matvec_mac_lanes_top.sv */
// ----------------------------------------------------------------------------
// matvec_mac_lanes_top: matrix-vector multiply-accumulate over lane groups
// Accumulator bank of Q16.16 values, four lanes side by side, with preload,
// multiply-accumulate and read actions on one group per item.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on req; each names an action, a group, a weight and four lane
// values. Every item yields exactly one result item on rsp with the group and
// the four lane contents after the action, plus a flag that is set when any
// lane sum clamped to the 32-bit signed range.
// An item is taken in the idle state, its group is read from the lane
// memories while the lane multipliers form the products, and in the write
// state the lanes write back and the result is loaded into the output
// register. No new item is taken until the previous one has passed the
// memory read and multiply stage and been written back; the result then
// waits on rsp in the output register until the receiver takes it.
// The output register holds a result while the next item is taken; if the
// receiver stalls, the write-back waits until the register is free.
// Reset clears the controller and the output valid; the accumulators hold
// no defined value until a group is preloaded.
// ----------------------------------------------------------------------------
module matvec_mac_lanes_top #(
    parameter int LANES  = mvm_pkg::DEF_LANES,
    parameter int GROUPS = mvm_pkg::DEF_GROUPS
) (
    input  logic         clk,
    input  logic         rst_n,
    mvm_stream_if.sink   req,
    mvm_stream_if.source rsp
);

    localparam int ACTIVE = (LANES < mvm_pkg::ITEM_LANES) ? LANES : mvm_pkg::ITEM_LANES;
    localparam int AW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

    mvm_pkg::state_t    state_reg;
    mvm_pkg::state_t    state_next;
    mvm_pkg::in_item_t  item_reg;
    mvm_pkg::lane_ctl_t ctl;
    logic               in_range;
    logic               out_free;
    logic               load;
    logic [AW-1:0]      addr;
    mvm_pkg::q_t        cols [mvm_pkg::ITEM_LANES];
    mvm_pkg::q_t        vals [mvm_pkg::ITEM_LANES];
    logic [mvm_pkg::ITEM_LANES-1:0] sats;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mvm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        unique case (state_reg)
            mvm_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = mvm_pkg::ST_LOAD;
                end
            end
            mvm_pkg::ST_LOAD:
            begin
                state_next = mvm_pkg::ST_WRITE;
            end
            mvm_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = mvm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mvm_pkg::ST_IDLE;
            end
        endcase
    end

    assign req.ready = (state_reg == mvm_pkg::ST_IDLE);

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.data;
        end
    end

    assign in_range = 32'(item_reg.group) < GROUPS;
    assign addr     = AW'(item_reg.group);

    assign ctl.rd_en      = (state_reg == mvm_pkg::ST_LOAD);
    assign ctl.is_preload = (item_reg.action == mvm_pkg::ACT_PRELOAD);
    assign ctl.is_mac     = (item_reg.action == mvm_pkg::ACT_MAC);
    assign ctl.wr_en      = load && in_range && (ctl.is_preload || ctl.is_mac);

    assign cols[0] = item_reg.lane_a;
    assign cols[1] = item_reg.lane_b;
    assign cols[2] = item_reg.lane_c;
    assign cols[3] = item_reg.lane_d;

    for (genvar j = 0; j < mvm_pkg::ITEM_LANES; j++)
    begin : g_lane
        if (j < ACTIVE)
        begin : g_on
            mvm_lane #(
                .GROUPS (GROUPS),
                .AW     (AW)
            ) u_lane (
                .clk    (clk),
                .ctl    (ctl),
                .addr   (addr),
                .weight (item_reg.weight),
                .col    (cols[j]),
                .value  (vals[j]),
                .sat    (sats[j])
            );
        end
        else
        begin : g_off
            assign vals[j] = '0;
            assign sats[j] = 1'b0;
        end
    end

    mvm_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .group    (item_reg.group),
        .in_range (in_range),
        .vals     (vals),
        .sats     (sats),
        .free     (out_free),
        .rsp      (rsp)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for matvec_mac_lanes_top
// Drives preload, multiply-accumulate and read items into the accumulator
// bank and predicts every result in Q16.16 with floor rounding and 32-bit
// saturation. Each result is compared field by field, in order. The run
// starts with a directed set of edge values, then applies random items with
// random idling on both channels, one long receiver hold and one full drain.
// ----------------------------------------------------------------------------
module testbench;

    import mvm_pkg::*;

    localparam int BANK_GROUPS = DEF_GROUPS;
    localparam int GROUP_LANES = ITEM_LANES;
    localparam int RANDOM_ITEMS = 800;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 40;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;
    localparam q_t Q_ONE = 32'sh0001_0000;
    localparam q_t Q_NEG_ONE = -32'sh0001_0000;
    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    class mac_scoreboard;
        q_t bank [0:BANK_GROUPS*GROUP_LANES-1];
        out_item_t expected_q [$];
        int errors;
        int results_seen;
        int n_preload;
        int n_mac;
        int n_read;
        int n_sat;

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] %s", $time, msg);
        endtask

        function q_t mac_lane(q_t acc, q_t w, q_t x, inout bit sat);
            longint prod;
            longint sum;
            prod = longint'(w) * longint'(x);
            sum = longint'(acc) + (prod >>> FRAC_BITS);
            if (sum > SUM_MAX)
            begin
                sat = 1'b1;
                return Q_MAX;
            end
            if (sum < SUM_MIN)
            begin
                sat = 1'b1;
                return Q_MIN;
            end
            return q_t'(sum);
        endfunction

        function void note_input(in_item_t it);
            q_t lanes [GROUP_LANES];
            out_item_t r;
            int base;
            bit sat;
            lanes = '{it.lane_a, it.lane_b, it.lane_c, it.lane_d};
            base = int'(it.group) * GROUP_LANES;
            sat = 1'b0;
            case (it.action)
                ACT_PRELOAD: n_preload++;
                ACT_MAC:     n_mac++;
                default:     n_read++;
            endcase
            for (int j = 0; j < GROUP_LANES; j++)
            begin
                case (it.action)
                    ACT_PRELOAD: bank[base+j] = lanes[j];
                    ACT_MAC:     bank[base+j] = mac_lane(bank[base+j], it.weight, lanes[j], sat);
                    default:     ;
                endcase
            end
            r.group_out = it.group;
            r.acc_a = bank[base];
            r.acc_b = bank[base+1];
            r.acc_c = bank[base+2];
            r.acc_d = bank[base+3];
            r.saturated = sat;
            expected_q.push_back(r);
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            q_t got_acc [GROUP_LANES];
            q_t want_acc [GROUP_LANES];
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result for group %0d with no item outstanding",
                    got.group_out));
                return;
            end
            want = expected_q.pop_front();
            if (want.saturated)
                n_sat++;
            if (got.group_out !== want.group_out)
                report_mismatch($sformatf("group_out: got %0d, expected %0d",
                    got.group_out, want.group_out));
            got_acc = '{got.acc_a, got.acc_b, got.acc_c, got.acc_d};
            want_acc = '{want.acc_a, want.acc_b, want.acc_c, want.acc_d};
            for (int j = 0; j < GROUP_LANES; j++)
            begin
                if (got_acc[j] !== want_acc[j])
                    report_mismatch($sformatf("group %0d lane %0d: got %h, expected %h",
                        want.group_out, j, got_acc[j], want_acc[j]));
            end
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("group %0d saturated: got %b, expected %b",
                    want.group_out, got.saturated, want.saturated));
        endtask

        task flush_check();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int cycle_count;
    int items_sent;
    bit calm;
    bit hold_request;
    int hold_left;
    bit loaded [BANK_GROUPS];
    int loaded_groups [$];

    mac_scoreboard sb = new();

    mvm_stream_if #(.payload_t(in_item_t)) req_ch ();
    mvm_stream_if #(.payload_t(out_item_t)) rsp_ch ();

    matvec_mac_lanes_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                sb.note_input(req_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_result(rsp_ch.data);
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic in_item_t make_item(logic [1:0] action, int group, q_t weight,
                                           q_t a, q_t b, q_t c, q_t d);
        in_item_t it;
        it.action = action;
        it.group = group[GROUP_W-1:0];
        it.weight = weight;
        it.lane_a = a;
        it.lane_b = b;
        it.lane_c = c;
        it.lane_d = d;
        return it;
    endfunction

    function automatic q_t rand_q();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            return q_t'($urandom);
        if (pick < 35)
        begin
            case ($urandom_range(0, 6))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return '0;
                3: return -32'sd1;
                4: return 32'sd1;
                5: return Q_ONE;
                default: return Q_NEG_ONE;
            endcase
        end
        return q_t'($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
    endfunction

    function automatic in_item_t rand_item();
        int pick;
        int group;
        logic [1:0] action;
        pick = $urandom_range(0, 99);
        if (pick < 20 || loaded_groups.size() == 0)
        begin
            action = ACT_PRELOAD;
            group = $urandom_range(0, BANK_GROUPS - 1);
        end
        else
        begin
            if (pick < 78)
                action = ACT_MAC;
            else if (pick < 95)
                action = ACT_READ;
            else
                action = ACT_SPARE;
            group = loaded_groups[$urandom_range(0, loaded_groups.size() - 1)];
        end
        return make_item(action, group, rand_q(), rand_q(), rand_q(), rand_q(), rand_q());
    endfunction

    task automatic send_item(in_item_t it);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 7)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
        if (it.action == ACT_PRELOAD && !loaded[it.group])
        begin
            loaded[it.group] = 1'b1;
            loaded_groups.push_back(int'(it.group));
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.results_seen < items_sent);
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        send_item(make_item(ACT_PRELOAD, 0, Q_ONE, Q_MAX, Q_MIN, '0, -32'sd1));
        send_item(make_item(ACT_READ, 0, '0, '0, '0, '0, '0));
        send_item(make_item(ACT_PRELOAD, 63, '0, Q_ONE, Q_NEG_ONE,
                            32'sh7FFF_0000, 32'sh8001_0000));
        send_item(make_item(ACT_MAC, 63, Q_ONE, Q_ONE, Q_NEG_ONE,
                            32'sh0002_0000, -32'sh0002_0000));
        send_item(make_item(ACT_PRELOAD, 5, Q_MAX, '0, '0, '0, '0));
        send_item(make_item(ACT_MAC, 5, -32'sd1, 32'sd1, 32'sh0000_FFFF, Q_ONE, -32'sd1));
        send_item(make_item(ACT_MAC, 5, 32'sd1, 32'sh0000_FFFF, Q_ONE, -32'sd1,
                            -32'sh0001_0001));
        send_item(make_item(ACT_MAC, 5, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_item(make_item(ACT_MAC, 0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN));
        send_item(make_item(ACT_SPARE, 63, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
        send_item(make_item(ACT_READ, 5, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MIN));
        send_item(make_item(ACT_PRELOAD, 42, Q_MIN, 32'sh5555_5555, 32'shAAAA_AAAA,
                            32'sh0000_8000, -32'sh0000_8000));
        send_item(make_item(ACT_PRELOAD, 21, Q_MAX, 32'shAAAA_AAAA, 32'sh5555_5555,
                            Q_ONE, Q_NEG_ONE));
        send_item(make_item(ACT_MAC, 21, '0, Q_MAX, Q_MIN, Q_MAX, Q_MIN));
        send_item(make_item(ACT_MAC, 42, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX));
        send_item(make_item(ACT_READ, 42, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
        send_item(make_item(ACT_SPARE, 21, '0, '0, '0, '0, '0));
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200)
                calm = 1'b1;
            if (i == 300)
                hold_request = 1'b1;
            if (i == 450)
                calm = 1'b0;
            if (i == 600)
                drain_results();
            send_item(rand_item());
        end
        req_ch.valid <= 1'b0;

        while (sb.results_seen < items_sent)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.flush_check();

        $display("Run covered %0d preloads, %0d multiply-accumulates and %0d reads",
            sb.n_preload, sb.n_mac, sb.n_read);
        $display("%0d of %0d results had a clamped lane; %0d field errors counted",
            sb.n_sat, sb.results_seen, sb.errors);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
src/mvm_pkg.sv
src/mvm_stream_if.sv
src/mvm_lane.sv
src/mvm_merge.sv
src/matvec_mac_lanes_top.sv
verif/testbench.sv
